>>> hdl/tle_pkg.sv
// ============================================================================
// tle_pkg
// Shared types, character codes and result codes of the terminal line editor.
// ============================================================================
package tle_pkg;

    localparam int DEPTH_DEF = 128;

    // Received control characters
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_ETB = 8'h17;   // Ctrl-W, word erase
    localparam logic [7:0] CH_NAK = 8'h15;   // Ctrl-U, line erase
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;

    // Echo kinds
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_ECHO    = 3'd1;
    localparam logic [2:0] KIND_BELL    = 3'd2;
    localparam logic [2:0] KIND_ERASE   = 3'd3;
    localparam logic [2:0] KIND_CRLF    = 3'd4;
    localparam logic [2:0] KIND_REFUSED = 3'd5;

    localparam int ERASE_W = 7;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_POP,
        OP_REFUSE,
        OP_CR,
        OP_BELL,
        OP_BACK,
        OP_WORD,
        OP_KILL,
        OP_ECHO
    } op_t;

    typedef struct packed {
        logic load;
        logic rd_head;
        logic rd_tail;
        logic drop;
        logic clr_erased;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic count_zero;
        logic rdata_white;
        logic out_free;
    } dp_stat_t;

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

>>> hdl/tle_ram.sv
// ============================================================================
// tle_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tle_pkg::DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/tle_datapath.sv
// ============================================================================
// tle_datapath
// Ring store, line pointers, item latch and result register of the editor.
// ============================================================================
module tle_datapath #(
    parameter int DEPTH = tle_pkg::DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd,
    input  logic [7:0]         rx_char,
    input  tle_pkg::dp_cmd_t   ctl,
    output tle_pkg::dp_stat_t  stat,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [2:0]         echo_kind,
    output logic [7:0]         echo_char,
    output logic [6:0]         erase_count,
    output logic               read_valid,
    output logic [7:0]         read_char
);

    localparam int IDX_W = $clog2(DEPTH);
    // a ready line may fill the whole store
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = CNT_W + tle_pkg::ERASE_W;
    localparam logic [IDX_W-1:0] LAST     = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [EXT_W-1:0] SAT  = EXT_W'((1 << tle_pkg::ERASE_W) - 1);

    logic             cmd_reg;
    logic [7:0]       char_reg;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ready_reg, ready_next;
    logic [IDX_W-1:0] erased_reg, erased_next;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       kind_reg, kind_next;
    logic [7:0]       echo_reg, echo_next;
    logic [6:0]       erase_reg, erase_next;
    logic             rvalid_reg, rvalid_next;
    logic [7:0]       rchar_reg, rchar_next;

    logic [IDX_W-1:0] tail_dec, tail_inc, head_inc;
    logic [EXT_W-1:0] erased_ext, count_ext;
    logic [6:0]       erased_sat, count_sat;
    tle_pkg::op_t     op;
    logic             out_free;

    logic             wr_en;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;

    assign tail_dec = (tail_reg == '0) ? LAST : tail_reg - IDX_W'(1);
    assign tail_inc = (tail_reg == LAST) ? '0 : tail_reg + IDX_W'(1);
    assign head_inc = (head_reg == LAST) ? '0 : head_reg + IDX_W'(1);

    assign erased_ext = {{(EXT_W - IDX_W){1'b0}}, erased_reg};
    assign count_ext  = {{tle_pkg::ERASE_W{1'b0}}, count_reg};
    assign erased_sat = (erased_ext > SAT) ? 7'h7F : erased_ext[6:0];
    assign count_sat  = (count_ext > SAT) ? 7'h7F : count_ext[6:0];

    assign out_free = !out_valid_reg || out_ready;

    // Classify the latched item against the current line state
    always_comb
    begin
        priority if (cmd_reg)
        begin
            op = (ready_reg && (count_reg != '0)) ? tle_pkg::OP_POP : tle_pkg::OP_NONE;
        end
        else if (ready_reg)
        begin
            op = tle_pkg::OP_REFUSE;
        end
        else if (char_reg == tle_pkg::CH_CR)
        begin
            op = tle_pkg::OP_CR;
        end
        else if ((char_reg == tle_pkg::CH_BS) || (char_reg == tle_pkg::CH_DEL))
        begin
            op = (count_reg == '0) ? tle_pkg::OP_BELL : tle_pkg::OP_BACK;
        end
        else if (char_reg == tle_pkg::CH_ETB)
        begin
            op = tle_pkg::OP_WORD;
        end
        else if (char_reg == tle_pkg::CH_NAK)
        begin
            op = tle_pkg::OP_KILL;
        end
        else
        begin
            // keep one entry free for the closing newline
            op = (count_reg >= CNT_LAST) ? tle_pkg::OP_BELL : tle_pkg::OP_ECHO;
        end
    end

    assign stat.op          = op;
    assign stat.count_zero  = (count_reg == '0);
    assign stat.rdata_white = tle_pkg::is_white(rd_data);
    assign stat.out_free    = out_free;

    assign wr_en   = ctl.commit && ((op == tle_pkg::OP_CR) || (op == tle_pkg::OP_ECHO));
    assign wr_data = (op == tle_pkg::OP_CR) ? tle_pkg::CH_LF : char_reg;
    assign rd_en   = ctl.rd_head || ctl.rd_tail;
    assign rd_addr = ctl.rd_head ? head_reg : tail_dec;

    tle_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        ready_next     = ready_reg;
        erased_next    = erased_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        echo_next      = echo_reg;
        erase_next     = erase_reg;
        rvalid_next    = rvalid_reg;
        rchar_next     = rchar_reg;

        if (ctl.clr_erased)
        begin
            erased_next = '0;
        end

        // word erase walks back one entry per drop
        if (ctl.drop)
        begin
            tail_next   = tail_dec;
            count_next  = count_reg - CNT_W'(1);
            erased_next = erased_reg + IDX_W'(1);
        end

        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
            kind_next      = tle_pkg::KIND_NONE;
            echo_next      = '0;
            erase_next     = '0;
            rvalid_next    = 1'b0;
            rchar_next     = '0;
            unique case (op)
                tle_pkg::OP_NONE:
                begin
                    kind_next = tle_pkg::KIND_NONE;
                end
                tle_pkg::OP_POP:
                begin
                    head_next   = head_inc;
                    count_next  = count_reg - CNT_W'(1);
                    ready_next  = (count_reg != CNT_W'(1));
                    rvalid_next = 1'b1;
                    rchar_next  = rd_data;
                end
                tle_pkg::OP_REFUSE:
                begin
                    kind_next = tle_pkg::KIND_REFUSED;
                end
                tle_pkg::OP_CR:
                begin
                    tail_next  = tail_inc;
                    count_next = count_reg + CNT_W'(1);
                    ready_next = 1'b1;
                    kind_next  = tle_pkg::KIND_CRLF;
                end
                tle_pkg::OP_BELL:
                begin
                    kind_next = tle_pkg::KIND_BELL;
                end
                tle_pkg::OP_BACK:
                begin
                    tail_next  = tail_dec;
                    count_next = count_reg - CNT_W'(1);
                    kind_next  = tle_pkg::KIND_ERASE;
                    erase_next = 7'd1;
                end
                tle_pkg::OP_WORD:
                begin
                    kind_next  = tle_pkg::KIND_ERASE;
                    erase_next = erased_sat;
                end
                tle_pkg::OP_KILL:
                begin
                    // the open line always starts at head
                    tail_next  = head_reg;
                    count_next = '0;
                    kind_next  = tle_pkg::KIND_ERASE;
                    erase_next = count_sat;
                end
                tle_pkg::OP_ECHO:
                begin
                    tail_next  = tail_inc;
                    count_next = count_reg + CNT_W'(1);
                    kind_next  = tle_pkg::KIND_ECHO;
                    echo_next  = char_reg;
                end
                default:
                begin
                    kind_next = tle_pkg::KIND_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd;
            char_reg <= rx_char;
        end
        erased_reg <= erased_next;
        kind_reg   <= kind_next;
        echo_reg   <= echo_next;
        erase_reg  <= erase_next;
        rvalid_reg <= rvalid_next;
        rchar_reg  <= rchar_next;
    end

    assign out_valid   = out_valid_reg;
    assign echo_kind   = kind_reg;
    assign echo_char   = echo_reg;
    assign erase_count = erase_reg;
    assign read_valid  = rvalid_reg;
    assign read_char   = rchar_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("line count exceeds store capacity");

    a_ready_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (count_reg != '0))
        else $error("ready line holds no characters");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> out_free)
        else $error("result written over an untaken beat");

    a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.drop |-> (count_reg != '0) && !ready_reg)
        else $error("word erase dropped from an empty or ready line");
`endif

endmodule

>>> hdl/tle_ctrl.sv
// ============================================================================
// tle_ctrl
// Sequencer of the line editor: takes an item, runs the word-erase walk and
// hands the result to the output register.
// ============================================================================
module tle_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tle_pkg::dp_stat_t  stat,
    output tle_pkg::dp_cmd_t   ctl
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DECODE   = 5'b00010,
        S_WORD_RD  = 5'b00100,
        S_WORD_CHK = 5'b01000,
        S_EMIT     = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.op == tle_pkg::OP_POP)
                begin
                    // read data lands in time for the emit cycle
                    ctl.rd_head = 1'b1;
                    state_next  = S_EMIT;
                end
                else if (stat.op == tle_pkg::OP_WORD)
                begin
                    ctl.clr_erased = 1'b1;
                    state_next     = S_WORD_RD;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_WORD_RD:
            begin
                if (stat.count_zero)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    ctl.rd_tail = 1'b1;
                    state_next  = S_WORD_CHK;
                end
            end
            S_WORD_CHK:
            begin
                if (stat.rdata_white)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    ctl.drop   = 1'b1;
                    state_next = S_WORD_RD;
                end
            end
            S_EMIT:
            begin
                // hold until the result register can take the beat
                if (stat.out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WORD_CHK) |-> ($past(state_reg) == S_WORD_RD))
        else $error("word check entered without a store read");

    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after commit");

    a_decode_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> (state_reg == S_DECODE))
        else $error("accepted beat not decoded");
`endif

endmodule

>>> hdl/terminal_line_editor.sv
// Sequence: an accepted beat is decoded and its result is registered in the emit step;
// Ctrl-W walks back first, with a store read and check per erased character, plus one
// more read and check when it stops at white space. A new item is taken only once the
// last result is committed; a Ctrl-W erases at most DEPTH-1 characters; a held result stalls.
// Reset: rst_n clears pointers, count, line-ready flag and the result valid;
// the line store is not cleared and needs no clearing pass.
// ============================================================================
// terminal_line_editor
// Canonical terminal line editor over a ring store, with valid/ready input
// and output channels.
// ============================================================================
module terminal_line_editor #(
    parameter int DEPTH = tle_pkg::DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] rx_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] echo_kind,
    output logic [7:0] echo_char,
    output logic [6:0] erase_count,
    output logic       read_valid,
    output logic [7:0] read_char
);

    tle_pkg::dp_cmd_t  ctl;
    tle_pkg::dp_stat_t stat;

    tle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    tle_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rx_char     (rx_char),
        .ctl         (ctl),
        .stat        (stat),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .echo_kind   (echo_kind),
        .echo_char   (echo_char),
        .erase_count (erase_count),
        .read_valid  (read_valid),
        .read_char   (read_char)
    );

endmodule
